>>> sv/modexp_pkg.sv
// Package for the modular exponentiation core.
// Holds field widths, the reset modulus, sequencer state codes and the
// shared modular add step. Depends on nothing.
package modexp_pkg;

	// Field widths.
	localparam int unsigned RES_W = 31;
	localparam int unsigned IN_W  = 63;

	// Counter widths for the bit-serial loops.
	localparam int unsigned RED_CNT_W = $clog2(IN_W);
	localparam int unsigned MUL_CNT_W = $clog2(RES_W);

	// The modulus after reset.
	localparam logic [RES_W-1:0] MODULUS_RESET = RES_W'(1000000007);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_STEP   = 5'b00100,
		S_MUL    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	// Where a finished product goes.
	typedef enum logic {
		DST_ACC  = 1'b0,
		DST_BASE = 1'b1
	} dest_t;

	// Modular add: (a + b + cin) mod m, for a and b below m.
	// The sum stays below 2m, so one compare and subtract suffices.
	function automatic logic [RES_W-1:0] mod_add(
		input logic [RES_W-1:0] a,
		input logic [RES_W-1:0] b,
		input logic             cin,
		input logic [RES_W-1:0] m
	);
		logic [RES_W:0] sum;
		logic [RES_W:0] diff;
		sum  = {1'b0, a} + {1'b0, b} + {{RES_W{1'b0}}, cin};
		diff = sum - {1'b0, m};
		if (sum >= {1'b0, m}) begin
			mod_add = diff[RES_W-1:0];
		end else begin
			mod_add = sum[RES_W-1:0];
		end
	endfunction

endpackage

>>> sv/modular_exponentiation_core.sv
// Modular exponentiation core: base to the exponent modulo a configured modulus.
// Uses modexp_pkg for widths, state codes and the shared modular add step.
//
// Each word on the input channel carries a 63-bit base and a 63-bit exponent;
// one word with power = base^exponent mod modulus comes back. A single modular
// adder (add, compare, subtract on 32 bits) does all the arithmetic under a
// small sequencer. The base is first reduced one bit per cycle. Each modular
// product is then formed by shift-and-add over the 31 multiplier bits, with a
// doubling step for each bit and an extra add step for each set bit. The
// exponent is scanned from its least significant bit; each set bit costs a
// product into the accumulator, and each bit below the highest set bit costs
// a squaring. The input is not ready while an item is in work. A finished
// result sits in an output register so a new item can be taken while it
// waits. A modulus of zero behaves as one; the modulus may be written only
// while the core is idle.
module modular_exponentiation_core
	import modexp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write channel.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [RES_W-1:0] modulus,
	// Input channel.
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  base,
	input  logic [IN_W-1:0]  exponent,
	// Output channel.
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] power
);

	state_t                 state_q;
	logic [RES_W-1:0]       modulus_q;
	logic [RES_W-1:0]       mod_eff;
	logic [IN_W-1:0]        base_sh_q;
	logic [IN_W-1:0]        exp_q;
	logic [RES_W-1:0]       b_q;
	logic [RES_W-1:0]       acc_q;
	logic [RES_W-1:0]       r_q;
	logic [RES_W-1:0]       mx_q;
	logic [RES_W-1:0]       my_q;
	logic [RED_CNT_W-1:0]   red_cnt_q;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;
	logic                   phase_q;
	dest_t                  dst_q;
	logic                   out_valid_q;
	logic [RES_W-1:0]       power_q;
	logic [RES_W-1:0]       ua;
	logic [RES_W-1:0]       ub;
	logic                   ucin;
	logic [RES_W-1:0]       ures;
	logic                   mul_last;

	// A modulus of zero acts as one.
	assign mod_eff = (modulus_q == '0) ? RES_W'(1) : modulus_q;

	// Shared modular adder: doubling with an incoming bit while reducing the
	// base, doubling or adding the multiplicand while multiplying.
	always_comb begin
		ua   = r_q;
		ub   = r_q;
		ucin = 1'b0;
		if (state_q == S_REDUCE) begin
			ucin = base_sh_q[IN_W-1];
		end else if (phase_q) begin
			ub = mx_q;
		end
		ures = mod_add(ua, ub, ucin, mod_eff);
	end

	// The product is finished when the last multiplier bit has been handled.
	assign mul_last = (mul_cnt_q == '0) && (phase_q || !my_q[RES_W-1]);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign power     = power_q;

	// Modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_valid) begin
			modulus_q <= modulus;
		end
	end

	// Output word flag: set when a result is handed over, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (red_cnt_q == '0) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (exp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
						phase_q <= 1'b0;
					end
				end
				S_MUL: begin
					if (mul_last) begin
						state_q <= S_STEP;
						phase_q <= 1'b0;
					end else if (!phase_q && my_q[RES_W-1]) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// Load the item; the accumulator starts at one, or zero for a modulus
				// of one with a nonzero exponent, so residues stay below the modulus.
				base_sh_q <= base;
				exp_q     <= exponent;
				r_q       <= '0;
				red_cnt_q <= RED_CNT_W'(IN_W - 1);
				if (exponent == '0 || mod_eff != RES_W'(1)) begin
					acc_q <= RES_W'(1);
				end else begin
					acc_q <= '0;
				end
			end
			S_REDUCE: begin
				// Long division of the base, one bit per cycle.
				r_q       <= ures;
				base_sh_q <= base_sh_q << 1;
				red_cnt_q <= red_cnt_q - 1'b1;
				if (red_cnt_q == '0) begin
					b_q <= ures;
				end
			end
			S_STEP: begin
				// Set bit: multiply into the accumulator and clear the bit.
				// Clear bit with more above: square the base and shift.
				r_q       <= '0;
				mul_cnt_q <= MUL_CNT_W'(RES_W - 1);
				if (exp_q[0]) begin
					mx_q  <= acc_q;
					my_q  <= b_q;
					dst_q <= DST_ACC;
					exp_q <= {exp_q[IN_W-1:1], 1'b0};
				end else begin
					mx_q  <= b_q;
					my_q  <= b_q;
					dst_q <= DST_BASE;
					exp_q <= exp_q >> 1;
				end
			end
			S_MUL: begin
				// Shift-and-add product, multiplier scanned from its top bit.
				r_q <= ures;
				if (phase_q || !my_q[RES_W-1]) begin
					my_q      <= my_q << 1;
					mul_cnt_q <= mul_cnt_q - 1'b1;
				end
				if (mul_last) begin
					if (dst_q == DST_ACC) begin
						acc_q <= ures;
					end else begin
						b_q <= ures;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					power_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> test/tb_modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the modular exponentiation core.
// Depends on modexp_pkg and modular_exponentiation_core; a scoreboard class
// predicts each power word; tasks and a receiver block drive the three channels.
module tb_modular_exponentiation_core;
	import modexp_pkg::*;

	// Longest run of cycles with no word moving on any channel.
	localparam int QUIET_LIMIT = 100000;
	// Length of the long receiver hold-off that fills the core.
	localparam int HOLD_OFF_CYCLES = 16000;
	localparam logic [IN_W-1:0] ALL_ONES = {IN_W{1'b1}};
	localparam logic [IN_W-1:0] ODD_BITS = IN_W'({(IN_W+1)/2{2'b01}});
	localparam logic [IN_W-1:0] EVEN_BITS = ODD_BITS >> 1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [RES_W-1:0] modulus;
	logic             in_valid;
	logic             in_ready;
	logic [IN_W-1:0]  base;
	logic [IN_W-1:0]  exponent;
	logic             out_valid;
	logic             out_ready;
	logic [RES_W-1:0] power;

	// Idle odds in percent for each side, set per phase.
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off_pending;

	// Scoreboard: tracks the modulus and holds one expected power per item.
	class power_scoreboard;
		bit [RES_W-1:0] cur_modulus;
		bit [RES_W-1:0] expected_powers[$];
		int errors;

		function new();
			cur_modulus = MODULUS_RESET;
			errors = 0;
		endfunction

		function void set_modulus(bit [RES_W-1:0] m);
			cur_modulus = m;
		endfunction

		// Square-and-multiply over 64-bit words; residues stay below 2^31.
		function bit [RES_W-1:0] raise_power(bit [IN_W-1:0] b, bit [IN_W-1:0] e);
			bit [63:0]      m;
			bit [63:0]      acc;
			bit [63:0]      sq;
			bit [IN_W-1:0]  bits;
			m = (cur_modulus == 0) ? 64'd1 : 64'(cur_modulus);
			if (e == 0) begin
				return RES_W'(1);
			end
			acc = 64'd1;
			sq = 64'(b) % m;
			bits = e;
			while (bits != 0) begin
				if (bits[0]) begin
					acc = (acc * sq) % m;
				end
				sq = (sq * sq) % m;
				bits = bits >> 1;
			end
			return RES_W'(acc % m);
		endfunction

		function void note_input(bit [IN_W-1:0] b, bit [IN_W-1:0] e);
			expected_powers = {expected_powers, raise_power(b, e)};
		endfunction

		function int pending();
			return expected_powers.size();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_power(logic [RES_W-1:0] got);
			bit [RES_W-1:0] want;
			if (expected_powers.size() == 0) begin
				report($sformatf("power word %0d with no item waiting", got));
			end else begin
				want = expected_powers.pop_front();
				if (got !== want) begin
					report($sformatf("power %0d, expected %0d", got, want));
				end
			end
		endtask
	endclass

	power_scoreboard sb = new();

	modular_exponentiation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.modulus   (modulus),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base      (base),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.power     (power)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one input word, with a random gap first, and wait for it to go in.
	task automatic send_item(input bit [IN_W-1:0] b, input bit [IN_W-1:0] e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b, e);
	endtask

	// Stop offering and wait until every expected power has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Change the modulus once the core has gone idle.
	task automatic write_modulus(input bit [RES_W-1:0] m);
		drain();
		cfg_valid <= 1'b1;
		modulus <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_modulus(m);
	endtask

	// Random items: mostly short exponents so runs stay quick, with some
	// full-width exponents and bases near multiples of the modulus.
	task automatic run_random(input int count);
		bit [IN_W-1:0] b;
		bit [IN_W-1:0] e;
		bit [IN_W-1:0] m;
		int            pick;
		for (int i = 0; i < count; i++) begin
			m = IN_W'(sb.cur_modulus);
			pick = $urandom_range(0, 3);
			if (pick < 2) begin
				b = IN_W'({$urandom, $urandom});
			end else if (pick == 2) begin
				b = IN_W'($urandom_range(0, 63));
			end else begin
				b = m * IN_W'($urandom_range(0, 3)) + IN_W'($urandom_range(0, 2)) - IN_W'(1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				e = IN_W'({$urandom, $urandom});
			end else if (pick < 20) begin
				case ($urandom_range(0, 3))
					0: e = '0;
					1: e = IN_W'(1);
					2: e = IN_W'(2);
					default: e = IN_W'(1) << $urandom_range(0, IN_W - 1);
				endcase
			end else begin
				e = IN_W'({$urandom, $urandom}) & ((IN_W'(1) << $urandom_range(1, 14)) - IN_W'(1));
			end
			send_item(b, e);
		end
	endtask

	// Receiver: check each accepted power word, then pick the next ready.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_power(power);
			end
			if (hold_off_pending) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: give up when no word moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence: reset, directed items, then the random phases.
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		modulus = '0;
		in_valid = 1'b0;
		base = '0;
		exponent = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_pending = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus: zero exponent, zero base, full-width fields and
		// bases sitting on or next to the modulus.
		send_item('0, '0);
		send_item(ALL_ONES, '0);
		send_item('0, IN_W'(1));
		send_item(ALL_ONES, IN_W'(1));
		send_item(ALL_ONES, ALL_ONES);
		send_item(IN_W'(1), ALL_ONES);
		send_item(IN_W'(MODULUS_RESET), IN_W'(5));
		send_item(IN_W'(MODULUS_RESET) - IN_W'(1), IN_W'(2));
		send_item(IN_W'(MODULUS_RESET) + IN_W'(1), IN_W'(12345));
		send_item(IN_W'(2), IN_W'(1) << (IN_W - 1));
		send_item(ODD_BITS, EVEN_BITS);

		// Modulus of one: a zero exponent still gives one, anything else zero.
		write_modulus(RES_W'(1));
		send_item(ALL_ONES, '0);
		send_item(IN_W'(5), IN_W'(1));
		send_item(ALL_ONES, IN_W'(3));

		// Modulus of zero behaves as one.
		write_modulus('0);
		send_item(IN_W'(7), '0);
		send_item(ALL_ONES, IN_W'(1234));

		// Largest modulus.
		write_modulus({RES_W{1'b1}});
		send_item(IN_W'({RES_W{1'b1}}) - IN_W'(1), IN_W'(2));
		send_item(IN_W'({RES_W{1'b1}}), IN_W'(3));
		send_item(ALL_ONES, EVEN_BITS);
		send_item('0, '0);

		// Smallest modulus that leaves nonzero residues.
		write_modulus(RES_W'(2));
		send_item(IN_W'(3), IN_W'(7));
		send_item(IN_W'(4), IN_W'(1));

		// No idling; the receiver first holds off long enough to fill the core.
		write_modulus(RES_W'(1000000007));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_pending = 1'b1;
		run_random(30);

		// Sender mostly idle, random full-width modulus.
		write_modulus(RES_W'($urandom));
		send_idle_pct = 81;
		recv_stall_pct = 0;
		run_random(30);

		// Receiver mostly stalling, small modulus.
		write_modulus(RES_W'($urandom_range(1, 1000)));
		send_idle_pct = 0;
		recv_stall_pct = 81;
		run_random(30);

		// Both sides idling now and then, largest modulus.
		write_modulus({RES_W{1'b1}});
		send_idle_pct = 21;
		recv_stall_pct = 21;
		run_random(30);

		drain();
		repeat (100) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d power words never came back", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/modexp_pkg.sv
sv/modular_exponentiation_core.sv
test/tb_modular_exponentiation_core.sv
